/* rtl/dbba_pkg.sv */
package dbba_pkg;

	localparam int MAX_BLOCKS = 32;
	localparam int SIZE_W    = 24;
	localparam int BSIZE_W   = 16;
	localparam int NBLK_W    = 6;
	localparam int STATUS_W  = 2;
	localparam int INDEX_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = NBLK_W + BSIZE_W;

	localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

	localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST    = 16'd1;
	localparam logic [NBLK_W-1:0]  BLOCKS_IN_USE_RST = 6'd32;

	typedef struct packed {
		logic                load;
		logic                mul;
		logic                emit_single;
		logic [STATUS_W-1:0] single_code;
		logic                step;
		logic                grant;
	} dbba_cmd_t;

	typedef struct packed {
		logic size_zero;
		logic too_big;
		logic bit_free;
		logic is_last;
		logic out_free;
	} dbba_sts_t;

endpackage

/* rtl/dbba_ctrl.sv */
module dbba_ctrl
	import dbba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  dbba_sts_t sts,
	output dbba_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_SCAN = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				priority if (sts.size_zero) begin
					if (sts.out_free) begin
						cmd.emit_single = 1'b1;
						cmd.single_code = ST_ZERO;
						state_d         = S_IDLE;
					end
				end else if (sts.too_big) begin
					if (sts.out_free) begin
						cmd.emit_single = 1'b1;
						cmd.single_code = ST_TOO_BIG;
						state_d         = S_IDLE;
					end
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (!sts.bit_free) begin
					cmd.step = 1'b1;
				end else if (sts.out_free) begin
					cmd.grant = 1'b1;
					cmd.step  = 1'b1;
					if (sts.is_last) begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_SCAN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/dbba_dp.sv */
module dbba_dp
	import dbba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SIZE_W-1:0]    file_size,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BSIZE_W-1:0]   cfg_data,
	input  dbba_cmd_t            cmd,
	output dbba_sts_t            sts,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [INDEX_W-1:0]   block_index,
	output logic                 last
);

	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	function automatic logic [NBLK_W-1:0] managed(input logic [NBLK_W-1:0] n);
		managed = ({1'b0, n} > (NBLK_W + 1)'(MAX_BLOCKS)) ? NBLK_W'(MAX_BLOCKS) : n;
	endfunction

	logic [BSIZE_W-1:0]    block_size_q;
	logic [NBLK_W-1:0]     blocks_in_use_q;
	logic [MAX_BLOCKS-1:0] used_map_q;
	logic [NBLK_W-1:0]     free_q;
	logic [SIZE_W-1:0]     rem_q;
	logic [CNT_W-1:0]      idx_q;
	logic [PROD_W-1:0]     prod_s1;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [INDEX_W-1:0]    index_q;
	logic                  last_q;

	logic [BSIZE_W-1:0]    bs_eff;
	logic [IDX_W-1:0]      map_idx;
	logic                  cfg_hit;
	logic [NBLK_W-1:0]     new_managed;

	assign bs_eff  = (block_size_q == '0) ? BSIZE_W'(1) : block_size_q;
	assign map_idx = idx_q[IDX_W-1:0];
	assign cfg_hit = cfg_we && (cfg_index == REG_BLOCK_SIZE || cfg_index == REG_BLOCKS_IN_USE);
	assign new_managed = (cfg_index == REG_BLOCKS_IN_USE) ? managed(cfg_data[NBLK_W-1:0])
	                                                      : managed(blocks_in_use_q);

	assign sts.size_zero = (rem_q == '0);
	assign sts.too_big   = (rem_q > SIZE_W'(prod_s1));
	assign sts.bit_free  = !used_map_q[map_idx];
	assign sts.is_last   = (rem_q <= SIZE_W'(bs_eff));
	assign sts.out_free  = !out_valid_q || !res_stall;

	assign res_valid   = out_valid_q;
	assign status      = status_q;
	assign block_index = index_q;
	assign last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q    <= BLOCK_SIZE_RST;
			blocks_in_use_q <= BLOCKS_IN_USE_RST;
			used_map_q      <= '0;
			free_q          <= managed(BLOCKS_IN_USE_RST);
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_hit) begin
				if (cfg_index == REG_BLOCK_SIZE) begin
					block_size_q <= cfg_data;
				end else begin
					blocks_in_use_q <= cfg_data[NBLK_W-1:0];
				end
				used_map_q <= '0;
				free_q     <= new_managed;
			end else if (cmd.grant) begin
				used_map_q[map_idx] <= 1'b1;
				free_q              <= free_q - NBLK_W'(1);
			end
			if (cmd.grant || cmd.emit_single) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= file_size;
			idx_q <= '0;
		end else begin
			if (cmd.grant) begin
				rem_q <= rem_q - SIZE_W'(bs_eff);
			end
			if (cmd.step) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(free_q) * PROD_W'(bs_eff);
		end
		if (cmd.emit_single) begin
			status_q <= cmd.single_code;
			index_q  <= '0;
			last_q   <= 1'b1;
		end else if (cmd.grant) begin
			status_q <= ST_GRANTED;
			index_q  <= INDEX_W'(idx_q);
			last_q   <= sts.is_last;
		end
	end

endmodule

/* rtl/disk_block_bitmap_allocator_top.sv */
// Channel   Direction  Handshake                  Payload
// request   in         req_valid / req_stall      file_size
// result    out        res_valid / res_stall      status, block_index, last
// config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A request is loaded, then free_count times block_size is formed and compared.
// A granted request then walks the used map one bit per cycle, unless a stalled result
// holds it at a free bit; rejected and zero-size requests end after the compare.
// Reset and every write to REG_BLOCK_SIZE or REG_BLOCKS_IN_USE free all blocks at once.
// A stalled result holds the scan; the next request is taken once the last result is
// in the output register.
module disk_block_bitmap_allocator_top
	import dbba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [SIZE_W-1:0]    file_size,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [INDEX_W-1:0]   block_index,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BSIZE_W-1:0]   cfg_data
);

	dbba_cmd_t cmd;
	dbba_sts_t sts;

	assign cfg_ready = 1'b1;

	dbba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dbba_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.file_size   (file_size),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.block_index (block_index),
		.last        (last)
	);

`ifndef ASSERT_OFF
	a_grant_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.grant || cmd.emit_single) |-> sts.out_free)
		else $error("result pushed over a pending result");

	a_grant_free_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grant |-> sts.bit_free)
		else $error("granted a block already in use");

	a_single_push: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.grant && cmd.emit_single))
		else $error("two results pushed in one cycle");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> req_stall)
		else $error("request taken without entering the allocation sequence");
`endif

endmodule
